[hw/rtl/salc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants shared by the LRU cache model front end, back end and top.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int ActWidth  = 2;
    localparam int OutcWidth = 2;
    localparam int CntWidth  = 32;
    localparam int CfgWidth  = 6;
    localparam int IdxWidth  = 2;

    typedef enum logic [1:0]
    {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_OTHER  = 2'd3
    } action_t;

    typedef enum logic [1:0]
    {
        OUTC_HIT   = 2'd0,
        OUTC_FILL  = 2'd1,
        OUTC_EVICT = 2'd2,
        OUTC_NONE  = 2'd3
    } outcome_t;

    typedef enum logic [1:0]
    {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        BE_IDLE   = 2'd0,
        BE_READ   = 2'd1,
        BE_UPDATE = 2'd2,
        BE_CLEAR  = 2'd3
    } be_state_t;

    localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};

    function automatic logic [CntWidth-1:0] sat_add(input logic [CntWidth-1:0] a,
                                                    input logic [1:0] b);
        logic [CntWidth:0] s;
        s = {1'b0, a} + {{(CntWidth-1){1'b0}}, b};
        return s[CntWidth] ? CntMax : s[CntWidth-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/salc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[hw/rtl/salc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_front
// Accepts an access, splits the address into set and tag, queues the request.
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int MaxSetBits = 6,
    parameter int AddrWidth  = 64,
    parameter int QDepth     = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [salc_pkg::ActWidth-1:0] action,
    input  wire logic [63:0]                   address,
    input  wire logic [2:0]                    set_bits,
    input  wire logic [5:0]                    block_bits,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output logic                               q_modify,
    output logic [MaxSetBits-1:0]              q_set,
    output logic [AddrWidth-1:0]               q_tag
);
    import salc_pkg::*;

    localparam int QW = $clog2(QDepth);
    localparam int EW = 1 + MaxSetBits + AddrWidth;

    logic [EW-1:0] q_mem [QDepth];
    logic [QW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QW:0]   cnt_reg, cnt_next;

    logic [AddrWidth-1:0]  addr_m;
    logic [6:0]            sb, shift;
    logic [MaxSetBits-1:0] set_c;
    logic [AddrWidth-1:0]  tag_c, set_mask;
    logic                  push, pop;

    always_comb
    begin
        addr_m   = address[AddrWidth-1:0];
        sb       = ({4'd0, set_bits} > 7'(MaxSetBits)) ? 7'(MaxSetBits) : {4'd0, set_bits};
        shift    = sb + {1'b0, block_bits};
        set_mask = ~({AddrWidth{1'b1}} << sb);
        set_c    = MaxSetBits'((addr_m >> block_bits) & set_mask);
        tag_c    = (shift >= 7'(AddrWidth)) ? '0 : (addr_m >> shift);
    end

    assign in_ready = (cnt_reg != (QW+1)'(QDepth));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign {q_modify, q_set, q_tag} = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? QW'((32'(wp_reg) + 1) % QDepth) : wp_reg;
        rp_next  = pop  ? QW'((32'(rp_reg) + 1) % QDepth) : rp_reg;
        cnt_next = cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= {(action == ACT_MODIFY), set_c, tag_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always @(posedge clk)
    begin
        a_no_overflow: assert property (disable iff (!rst_n)
            cnt_reg == (QW+1)'(QDepth) |-> !push) else $error("queue overflow");
        a_no_underflow: assert property (disable iff (!rst_n)
            cnt_reg == '0 |-> !pop) else $error("queue underflow");
        a_count: assert property (disable iff (!rst_n)
            push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
    end
endmodule
`default_nettype wire

[hw/rtl/salc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_back
// Reads one set, compares tags, updates LRU ranks and totals, holds result.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int MaxSetBits = 6,
    parameter int MaxWays    = 8,
    parameter int AddrWidth  = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire logic                           q_modify,
    input  wire logic [MaxSetBits-1:0]          q_set,
    input  wire logic [AddrWidth-1:0]           q_tag,
    input  wire logic [3:0]                     ways_in_use,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [salc_pkg::OutcWidth-1:0]      outcome,
    output logic [1:0]                          hits_added,
    output logic [salc_pkg::CntWidth-1:0]       total_hits,
    output logic [salc_pkg::CntWidth-1:0]       total_misses,
    output logic [salc_pkg::CntWidth-1:0]       total_evictions
);
    import salc_pkg::*;

    localparam int Sets = 1 << MaxSetBits;
    localparam int WW   = (MaxWays > 1) ? $clog2(MaxWays) : 1;
    localparam int RW   = $clog2(MaxWays + 1);
    // line word: {valid, tag, rank}
    localparam int LW   = 1 + AddrWidth + RW;

    be_state_t state_reg, state_next;
    logic [MaxSetBits-1:0] clr_reg;
    logic [MaxSetBits-1:0] set_reg;
    logic [AddrWidth-1:0]  tag_reg;
    logic                  mod_reg;
    logic [CntWidth-1:0]   hit_reg, miss_reg, evict_reg;
    logic [1:0]            outc_reg, added_reg;
    logic                  ov_reg;

    logic [MaxWays-1:0]      we;
    logic [MaxWays-1:0][LW-1:0] rd, wd;
    logic [MaxSetBits-1:0]   ram_addr;
    logic [RW-1:0]           ways;
    logic [MaxWays-1:0]      used, hitv, freev;
    logic                    hit, free_any;
    logic [WW-1:0]           sel;
    logic [RW-1:0]           old_rank;
    logic [1:0]              outc_c, added_c;
    logic                    accept, upd, clr;

    genvar g;
    generate
        for (g = 0; g < MaxWays; g++)
        begin : g_way
            salc_ram #(.Width(LW), .Depth(Sets)) u_ram (
                .clk(clk), .we(we[g]), .addr(ram_addr), .wdata(wd[g]), .rdata(rd[g]));
        end
    endgenerate

    always_comb
    begin
        ways = (ways_in_use == 4'd0) ? RW'(1)
             : (int'(ways_in_use) > MaxWays) ? RW'(MaxWays) : RW'(ways_in_use);
        for (int j = 0; j < MaxWays; j++)
        begin
            used[j]  = (RW'(j) < ways);
            hitv[j]  = used[j] && rd[j][LW-1] && rd[j][LW-2:RW] == tag_reg;
            freev[j] = used[j] && !rd[j][LW-1];
        end
        hit      = |hitv;
        free_any = |freev;
        sel      = '0;
        old_rank = '0;
        if (hit)
        begin
            for (int j = MaxWays-1; j >= 0; j--)
                if (hitv[j]) sel = WW'(j);
            old_rank = rd[sel][RW-1:0];
        end
        else if (free_any)
        begin
            for (int j = MaxWays-1; j >= 0; j--)
                if (freev[j]) sel = WW'(j);
        end
        else
        begin
            for (int j = MaxWays-1; j >= 1; j--)
                if (used[j] && rd[j][RW-1:0] < rd[0][RW-1:0]) sel = WW'(j);
            // pick lowest rank, lowest index on tie
            for (int j = 1; j < MaxWays; j++)
                if (used[j] && rd[j][RW-1:0] < rd[sel][RW-1:0]) sel = WW'(j);
            old_rank = rd[sel][RW-1:0];
        end
        outc_c  = hit ? OUTC_HIT : (free_any ? OUTC_FILL : OUTC_EVICT);
        added_c = {1'b0, hit} + {1'b0, mod_reg};
    end

    assign upd      = (state_reg == BE_UPDATE);
    assign clr      = (state_reg == BE_CLEAR);
    // set held from accept to write-back so the read in BE_READ stays on it
    assign ram_addr = clr ? clr_reg : ((state_reg == BE_IDLE) ? q_set : set_reg);

    always_comb
    begin
        for (int j = 0; j < MaxWays; j++)
        begin
            we[j] = clr || (upd && used[j] && (rd[j][LW-1] || WW'(j) == sel));
            if (clr)
                wd[j] = '0;
            else if (WW'(j) == sel)
                wd[j] = {1'b1, (hit ? rd[j][LW-2:RW] : tag_reg), ways};
            else if (rd[j][RW-1:0] > old_rank)
                wd[j] = {rd[j][LW-1:RW], rd[j][RW-1:0] - 1'b1};
            else
                wd[j] = rd[j];
        end
    end

    assign accept  = (state_reg == BE_IDLE) && q_valid && (!ov_reg || out_ready);
    assign q_ready = accept;

    always_comb
    begin
        unique case (state_reg)
            BE_CLEAR:  state_next = (&clr_reg) ? BE_IDLE : BE_CLEAR;
            BE_IDLE:   state_next = accept ? BE_READ : BE_IDLE;
            BE_READ:   state_next = BE_UPDATE;
            BE_UPDATE: state_next = BE_IDLE;
            default:   state_next = BE_IDLE;
        endcase
    end

    assign out_valid       = ov_reg;
    assign outcome         = outc_reg;
    assign hits_added      = added_reg;
    assign total_hits      = hit_reg;
    assign total_misses    = miss_reg;
    assign total_evictions = evict_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
            mod_reg <= q_modify;
        end
        if (upd)
        begin
            outc_reg  <= outc_c;
            added_reg <= added_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_CLEAR;
            clr_reg   <= '0;
            hit_reg   <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (upd)
            begin
                hit_reg   <= sat_add(hit_reg, added_c);
                if (!hit) miss_reg <= sat_add(miss_reg, 2'd1);
                if (!hit && !free_any) evict_reg <= sat_add(evict_reg, 2'd1);
                ov_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        a_upd_sets_valid: assert property (disable iff (!rst_n)
            upd |=> out_valid) else $error("result lost");
        a_read_then_upd: assert property (disable iff (!rst_n)
            state_reg == BE_READ |=> upd) else $error("sequence slip");
        a_no_overwrite: assert property (disable iff (!rst_n)
            upd |-> !ov_reg) else $error("result overwritten");
        a_clear_blocks: assert property (disable iff (!rst_n)
            clr |-> !q_ready) else $error("accept during clear");
    end
endmodule
`default_nettype wire

[hw/rtl/set_assoc_lru_cache_model.sv]
`default_nettype none
// An accepted access beat passes the queue, the set read and the update into the
//   output register before its result beat is offered.
// The back end takes no new access until the last one is through its set read and
//   read-modify-write of the per-way tag/rank/valid RAMs (one port each).
// Reset: totals and queue clear at once; config returns to 4 set bits, 4 block bits,
//   one way; the back end then clears every line, set by set.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache with true LRU and saturating hit/miss/evict totals.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS  = 6,
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [salc_pkg::IdxWidth-1:0] cfg_index,
    input  wire logic [salc_pkg::CfgWidth-1:0] cfg_data,
    // access beats
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [salc_pkg::ActWidth-1:0] action,
    input  wire logic [63:0]                   address,
    // result beats
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [salc_pkg::OutcWidth-1:0]     outcome,
    output logic [1:0]                         hits_added,
    output logic [salc_pkg::CntWidth-1:0]      total_hits,
    output logic [salc_pkg::CntWidth-1:0]      total_misses,
    output logic [salc_pkg::CntWidth-1:0]      total_evictions
);
    import salc_pkg::*;

    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;

    logic                     q_valid, q_ready, q_modify;
    logic [MAX_SET_BITS-1:0]  q_set;
    logic [ADDRESS_WIDTH-1:0] q_tag;

    // Registers: writes land immediately; the user must issue them only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd4;
            block_bits_reg <= 6'd4;
            ways_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Front: address split into set and full tag, two-entry queue.
    salc_front #(.MaxSetBits(MAX_SET_BITS), .AddrWidth(ADDRESS_WIDTH), .QDepth(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .address(address), .set_bits(set_bits_reg),
        .block_bits(block_bits_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_modify(q_modify), .q_set(q_set), .q_tag(q_tag));

    // Back: set lookup, LRU update, totals and output register.
    salc_back #(.MaxSetBits(MAX_SET_BITS), .MaxWays(MAX_WAYS),
                .AddrWidth(ADDRESS_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_modify(q_modify), .q_set(q_set), .q_tag(q_tag), .ways_in_use(ways_reg),
        .out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
        .hits_added(hits_added), .total_hits(total_hits),
        .total_misses(total_misses), .total_evictions(total_evictions));

    always @(posedge clk)
    begin
        a_evict_implies_miss: assert property (disable iff (!rst_n)
            out_valid && outcome == OUTC_EVICT |-> total_misses != '0) else $error("evict w/o miss");
        a_ways_sane: assert property (disable iff (!rst_n)
            out_valid |-> outcome != OUTC_NONE) else $error("bad outcome");
        a_hits_sane: assert property (disable iff (!rst_n)
            out_valid && outcome == OUTC_HIT |-> hits_added != 2'd0) else $error("hit not counted");
    end
endmodule
`default_nettype wire

[tb/tb_set_assoc_lru_cache_model.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model
// Drives cache accesses through valid/ready, predicts each result with an
// in-bench LRU cache model and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_model;

    import salc_pkg::*;

    localparam int MaxSetBits = 6;
    localparam int MaxWays    = 8;
    localparam int NumLines   = (1 << MaxSetBits) * MaxWays;

    typedef struct packed
    {
        logic [1:0]  act;
        logic [63:0] addr;
    } access_t;

    typedef struct packed
    {
        logic [1:0]  outc;
        logic [1:0]  added;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } cache_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [ActWidth-1:0] action;
    logic [63:0] address;
    logic out_valid;
    logic out_ready;
    logic [OutcWidth-1:0] outcome;
    logic [1:0] hits_added;
    logic [CntWidth-1:0] total_hits;
    logic [CntWidth-1:0] total_misses;
    logic [CntWidth-1:0] total_evictions;

    set_assoc_lru_cache_model uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .outcome         (outcome),
        .hits_added      (hits_added),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions)
    );

    // Predictor state: a private copy of configuration, lines and totals.
    logic [2:0]  cur_set_bits;
    logic [5:0]  cur_block_bits;
    logic [3:0]  cur_ways;
    logic        lv[NumLines];
    logic [63:0] ltag[NumLines];
    logic [3:0]  lrank[NumLines];
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;

    access_t       pending_accesses[$];
    cache_result_t expected_results[$];

    int  fail_count;
    bit  quiet;          // no idling in the closing stretch
    bit  hold_sender;    // pressure: sender waits for the pipe to drain
    int  in_gap, out_gap;

    function automatic logic [31:0] sat_inc(logic [31:0] a, logic [1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {31'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Age the ways above the old rank and make way w the newest.
    task automatic touch_way(int base, int ways, int w, logic [3:0] old_rank);
        for (int j = 0; j < ways; j++)
            if (lv[base + j] && lrank[base + j] > old_rank)
                lrank[base + j] = lrank[base + j] - 4'd1;
        lrank[base + w] = ways[3:0];
    endtask

    task automatic predict_access(access_t a);
        cache_result_t r;
        int sb, bb, ways, set_no, base, w, victim, shift;
        logic [63:0] tag;
        bit modify;
        modify = (a.act == ACT_MODIFY);
        sb     = (cur_set_bits > MaxSetBits) ? MaxSetBits : cur_set_bits;
        bb     = cur_block_bits;
        ways   = (cur_ways == 0) ? 1 : ((cur_ways > MaxWays) ? MaxWays : cur_ways);
        set_no = int'((a.addr >> bb) & ((64'd1 << sb) - 64'd1));
        shift  = sb + bb;
        tag    = (shift >= 64) ? 64'd0 : (a.addr >> shift);
        base   = set_no * MaxWays;
        for (w = 0; w < ways; w++)
            if (lv[base + w] && ltag[base + w] == tag)
                break;
        if (w < ways)
        begin
            r.outc  = OUTC_HIT;
            r.added = modify ? 2'd2 : 2'd1;
            touch_way(base, ways, w, lrank[base + w]);
        end
        else
        begin
            r.added  = modify ? 2'd1 : 2'd0;
            miss_cnt = sat_inc(miss_cnt, 2'd1);
            for (w = 0; w < ways; w++)
                if (!lv[base + w])
                    break;
            if (w < ways)
            begin
                r.outc = OUTC_FILL;
                lv[base + w]   = 1'b1;
                ltag[base + w] = tag;
                touch_way(base, ways, w, 4'd0);
            end
            else
            begin
                r.outc    = OUTC_EVICT;
                evict_cnt = sat_inc(evict_cnt, 2'd1);
                victim    = 0;
                for (int j = 1; j < ways; j++)
                    if (lrank[base + j] < lrank[base + victim])
                        victim = j;
                ltag[base + victim] = tag;
                touch_way(base, ways, victim, lrank[base + victim]);
            end
        end
        hit_cnt  = sat_inc(hit_cnt, r.added);
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
        expected_results.push_back(r);
    endtask

    // Clock, 8 time units per period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver: presents the head of the pending queue, idles in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= ACT_LOAD;
            address  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_access({action, address});
                void'(pending_accesses.pop_front());
            end
            if (in_valid && !in_ready)
                ;  // hold the beat
            else if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                in_gap   <= $urandom_range(1, 11) - 1;
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_accesses.size() == 0
                     || (in_valid && in_ready && pending_accesses.size() == 0))
                in_valid <= 1'b0;
            else
            begin
                in_valid <= 1'b1;
                action   <= pending_accesses[0].act;
                address  <= pending_accesses[0].addr;
            end
        end
    end

    // Monitor: random stalls on out_ready, compares each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (outcome !== e.outc)
                    begin
                        $error("outcome exp %0d got %0d", e.outc, outcome);
                        fail_count++;
                    end
                    if (hits_added !== e.added)
                    begin
                        $error("hits_added exp %0d got %0d", e.added, hits_added);
                        fail_count++;
                    end
                    if (total_hits !== e.hits)
                    begin
                        $error("total_hits exp %0d got %0d", e.hits, total_hits);
                        fail_count++;
                    end
                    if (total_misses !== e.misses)
                    begin
                        $error("total_misses exp %0d got %0d", e.misses, total_misses);
                        fail_count++;
                    end
                    if (total_evictions !== e.evicts)
                    begin
                        $error("total_evictions exp %0d got %0d", e.evicts,
                               total_evictions);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                out_gap   <= $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Wait until every queued beat has gone in and every result come back,
    // then let the block settle before the next step.
    task automatic drain();
        while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write while idle; predictor copy follows at once.
    task automatic write_cfg(cfg_idx_t idx, logic [CfgWidth-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SET_BITS:   cur_set_bits   = val[2:0];
            CFG_BLOCK_BITS: cur_block_bits = val[5:0];
            CFG_WAYS:       cur_ways       = val[3:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Address built from a small tag pool so that sets fill and evict.
    function automatic logic [63:0] pool_addr(int sb, int bb, int ntags);
        logic [63:0] a;
        a = rand64();
        if (sb + bb < 64)
            a = (a & ((64'd1 << (sb + bb)) - 64'd1))
                | (64'($urandom_range(0, ntags - 1)) << (sb + bb));
        if ($urandom_range(0, 7) == 0)
            a[63:60] = 4'hF;
        return a;
    endfunction

    function automatic logic [1:0] rand_act();
        return 2'($urandom_range(0, 3));
    endfunction

    task automatic random_phase(int n, int sb, int bb, int ntags);
        for (int i = 0; i < n; i++)
            pending_accesses.push_back({rand_act(),
                ($urandom_range(0, 9) == 0) ? rand64() : pool_addr(sb, bb, ntags)});
    endtask

    initial
    begin
        fail_count = 0;
        quiet = 1'b0;
        hold_sender = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data = '0;
        cur_set_bits = 3'd4;
        cur_block_bits = 6'd4;
        cur_ways = 4'd1;
        hit_cnt = 0;
        miss_cnt = 0;
        evict_cnt = 0;
        for (int i = 0; i < NumLines; i++)
        begin
            lv[i] = 1'b0;
            ltag[i] = '0;
            lrank[i] = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset config, every action, address extremes.
        pending_accesses.push_back({ACT_LOAD, 64'd0});
        pending_accesses.push_back({ACT_STORE, 64'd0});
        pending_accesses.push_back({ACT_MODIFY, 64'd0});
        pending_accesses.push_back({ACT_OTHER, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_accesses.push_back({ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_accesses.push_back({ACT_LOAD, 64'h100});
        pending_accesses.push_back({ACT_LOAD, 64'h0});
        drain();

        // Full associativity, tiny sets: fills, then LRU evictions.
        write_cfg(CFG_SET_BITS, 6'd1);
        write_cfg(CFG_BLOCK_BITS, 6'd1);
        write_cfg(CFG_WAYS, 6'd8);
        for (int t = 0; t < 10; t++)
            pending_accesses.push_back({ACT_LOAD, 64'(t) << 2});
        pending_accesses.push_back({ACT_MODIFY, 64'd8});
        pending_accesses.push_back({ACT_STORE, 64'd36});
        drain();

        // Oversized fields: set bits saturate, ways saturate, tag zero.
        write_cfg(CFG_SET_BITS, 6'd7);
        write_cfg(CFG_BLOCK_BITS, 6'd63);
        write_cfg(CFG_WAYS, 6'd15);
        pending_accesses.push_back({ACT_LOAD, 64'h8000_0000_0000_0000});
        pending_accesses.push_back({ACT_LOAD, 64'h7FFF_FFFF_FFFF_FFFF});
        drain();
        write_cfg(CFG_SET_BITS, 6'd0);
        write_cfg(CFG_WAYS, 6'd0);
        write_cfg(CFG_BLOCK_BITS, 6'd0);
        pending_accesses.push_back({ACT_LOAD, 64'hA5});
        pending_accesses.push_back({ACT_MODIFY, 64'h5A});
        drain();

        // Random phases over a spread of settings.
        write_cfg(CFG_SET_BITS, 6'd2);
        write_cfg(CFG_BLOCK_BITS, 6'd3);
        write_cfg(CFG_WAYS, 6'd4);
        random_phase(200, 2, 3, 10);
        // pressure: part way in, sender stalls until every result is home
        while (pending_accesses.size() > 100)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || in_valid)
            @(posedge clk);
        hold_sender = 1'b0;
        drain();

        write_cfg(CFG_SET_BITS, 6'd6);
        write_cfg(CFG_BLOCK_BITS, 6'd32);
        write_cfg(CFG_WAYS, 6'd8);
        random_phase(200, 6, 32, 14);
        drain();

        write_cfg(CFG_SET_BITS, 6'd1);
        write_cfg(CFG_BLOCK_BITS, 6'd1);
        write_cfg(CFG_WAYS, 6'd3);
        random_phase(200, 1, 1, 6);
        drain();

        // Closing stretch: no idling on either side.
        write_cfg(CFG_SET_BITS, 6'd3);
        write_cfg(CFG_BLOCK_BITS, 6'd58);
        write_cfg(CFG_WAYS, 6'd5);
        quiet = 1'b1;
        random_phase(200, 3, 58, 8);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
